FILE: hw/rtl/eik_pkg.sv
// ----------------------------------------------------------------------------
// eik_pkg
// Shared constants for the 3-D upwind eikonal node update unit.
// ----------------------------------------------------------------------------
package eik_pkg;

   localparam int DIST_WIDTH_DEF = 32;
   localparam int SOS_WIDTH      = 24;
   localparam int MASK_WIDTH     = 6;

   localparam logic [SOS_WIDTH-1:0] SOS_RESET = 24'd65536;

   // squared differences use differences capped at 2^DIFF_CAP_LOG
   localparam int DIFF_CAP_LOG = 26;
   localparam int DIFF_WIDTH   = DIFF_CAP_LOG + 1;
   localparam int SQ_WIDTH     = 2 * DIFF_WIDTH;

   localparam int F2_WIDTH   = 2 * SOS_WIDTH;
   // discriminant is at most 3*f^2 < 2^50; one bit of headroom
   localparam int DISC_WIDTH = F2_WIDTH + 3;
   // root of the discriminant: 25 result bits, one per pipeline stage
   localparam int SQRT_ITERS = 25;

   // long division by three, this many dividend bits per stage
   localparam int DIV_BITS = 4;

   // neighbor order in the edge mask
   localparam int NB_XM = 0;
   localparam int NB_XP = 1;
   localparam int NB_YM = 2;
   localparam int NB_YP = 3;
   localparam int NB_ZM = 4;
   localparam int NB_ZP = 5;

endpackage

FILE: hw/rtl/eikonal_node_update_3d_unit.sv
// ----------------------------------------------------------------------------
// eikonal_node_update_3d_unit
// Pipelined Godunov upwind local solver for one node of a 3-D distance grid.
// ----------------------------------------------------------------------------
// Input channel (req_*): one node per transaction, its distance, its six axis
// neighbors and an edge mask marking absent neighbors. Result channel (rsp_*):
// the new distance and an improved flag, one transaction per input, in order.
// csr_wr_en / csr_wr_data load the step-over-speed register (Q8.16); write it
// only while no transaction is in flight.
// Throughput: one transaction per cycle when the receiver does not stall. The
// datapath runs through two 25-stage square root pipelines (one bit of root per
// stage) and the divide-by-three pipeline (four bits per stage).
// Reset clears all valid bits and loads the register with 1.0.
// When the receiver stalls the whole pipeline holds in place; req_ready drops
// only while a result waits in the output register and rsp_ready is low, so
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module eikonal_node_update_3d_unit #(
   parameter int DIST_WIDTH = eik_pkg::DIST_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [DIST_WIDTH-1:0]           req_center_distance,
   input  logic [DIST_WIDTH-1:0]           req_x_minus,
   input  logic [DIST_WIDTH-1:0]           req_x_plus,
   input  logic [DIST_WIDTH-1:0]           req_y_minus,
   input  logic [DIST_WIDTH-1:0]           req_y_plus,
   input  logic [DIST_WIDTH-1:0]           req_z_minus,
   input  logic [DIST_WIDTH-1:0]           req_z_plus,
   input  logic [eik_pkg::MASK_WIDTH-1:0]  req_edge_mask,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [DIST_WIDTH-1:0]           rsp_new_distance,
   output logic                            rsp_improved,
   input  logic                            csr_wr_en,
   input  logic [eik_pkg::SOS_WIDTH-1:0]   csr_wr_data
);

   localparam int DW     = DIST_WIDTH;
   localparam int SW     = eik_pkg::SOS_WIDTH;
   localparam int DIFFW  = eik_pkg::DIFF_WIDTH;
   localparam int SQW    = eik_pkg::SQ_WIDTH;
   localparam int F2W    = eik_pkg::F2_WIDTH;
   localparam int DISCW  = eik_pkg::DISC_WIDTH;
   localparam int NSQ    = eik_pkg::SQRT_ITERS;
   // arithmetic width for all candidate sums
   localparam int AW     = ((DW > 26) ? DW : 26) + 2;
   localparam int DB     = eik_pkg::DIV_BITS;
   localparam int NDIV   = (AW + DB - 1) / DB;
   localparam int DIVW   = NDIV * DB;

   localparam logic [AW-1:0] DMAX_A   = AW'({DW{1'b1}});
   localparam logic [AW-1:0] DIFF_CAP = AW'(1) << eik_pkg::DIFF_CAP_LOG;

   typedef struct packed {
      logic [DW-1:0] u1;
      logic [DW-1:0] u2;
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      logic [DW-1:0] ctr;
      logic [AW-1:0] cb;
      logic [AW-1:0] psum;
   } carry_type;

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---------------- configuration register ----------------
   logic [SW-1:0] sos_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sos_ff <= eik_pkg::SOS_RESET;
      end else if (csr_wr_en) begin
         sos_ff <= csr_wr_data;
      end
   end

   // ---------------- stage 1: neighbor substitution, axis minima ----------------
   logic          p1_v_ff;
   logic [DW-1:0] p1_m0_ff, p1_m1_ff, p1_m2_ff, p1_ctr_ff;
   logic [SW-1:0] p1_f_ff;
   logic [DW-1:0] p1_m0_in, p1_m1_in, p1_m2_in;

   always_comb begin
      logic [DW-1:0] nb [6];
      nb[eik_pkg::NB_XM] = req_edge_mask[eik_pkg::NB_XM] ? req_center_distance : req_x_minus;
      nb[eik_pkg::NB_XP] = req_edge_mask[eik_pkg::NB_XP] ? req_center_distance : req_x_plus;
      nb[eik_pkg::NB_YM] = req_edge_mask[eik_pkg::NB_YM] ? req_center_distance : req_y_minus;
      nb[eik_pkg::NB_YP] = req_edge_mask[eik_pkg::NB_YP] ? req_center_distance : req_y_plus;
      nb[eik_pkg::NB_ZM] = req_edge_mask[eik_pkg::NB_ZM] ? req_center_distance : req_z_minus;
      nb[eik_pkg::NB_ZP] = req_edge_mask[eik_pkg::NB_ZP] ? req_center_distance : req_z_plus;
      p1_m0_in = (nb[0] < nb[1]) ? nb[0] : nb[1];
      p1_m1_in = (nb[2] < nb[3]) ? nb[2] : nb[3];
      p1_m2_in = (nb[4] < nb[5]) ? nb[4] : nb[5];
   end

   // ---------------- stage 2: sort, f^2 ----------------
   logic           p2_v_ff;
   logic [DW-1:0]  p2_a_ff, p2_b_ff, p2_c_ff, p2_ctr_ff;
   logic [SW-1:0]  p2_f_ff;
   logic [F2W-1:0] p2_f2_ff;
   logic [DW-1:0]  p2_a_in, p2_b_in, p2_c_in;
   logic [F2W-1:0] p2_f2_in;

   always_comb begin
      logic [DW-1:0] s0, s1, s2, t;
      t  = '0;
      s0 = p1_m0_ff;
      s1 = p1_m1_ff;
      s2 = p1_m2_ff;
      if (s0 > s1) begin
         t = s0; s0 = s1; s1 = t;
      end
      if (s1 > s2) begin
         t = s1; s1 = s2; s2 = t;
      end
      if (s0 > s1) begin
         t = s0; s0 = s1; s1 = t;
      end
      p2_c_in  = s0;
      p2_b_in  = s1;
      p2_a_in  = s2;
      p2_f2_in = p1_f_ff * p1_f_ff;
   end

   // ---------------- stage 3: differences, one-sided candidate, sums ----------------
   logic             p3_v_ff;
   logic [DIFFW-1:0] p3_dbc_ff, p3_dab_ff, p3_dac_ff;
   logic [F2W-1:0]   p3_f2_ff;
   carry_type        p3_cy_ff;
   logic [DIFFW-1:0] p3_dbc_in, p3_dab_in, p3_dac_in;
   carry_type        p3_cy_in;

   function automatic logic [DIFFW-1:0] cap_diff(input logic [DW-1:0] hi,
                                                 input logic [DW-1:0] lo);
      logic [AW-1:0] d;
      d = (hi >= lo) ? AW'(hi - lo) : AW'(lo - hi);
      if (d > DIFF_CAP) begin
         d = DIFF_CAP;
      end
      return d[DIFFW-1:0];
   endfunction

   always_comb begin
      logic [AW-1:0] u1w;
      p3_dbc_in = cap_diff(p2_b_ff, p2_c_ff);
      p3_dab_in = cap_diff(p2_a_ff, p2_b_ff);
      p3_dac_in = cap_diff(p2_a_ff, p2_c_ff);
      u1w = AW'(p2_c_ff) + AW'(p2_f_ff);
      p3_cy_in.u1   = (u1w > DMAX_A) ? {DW{1'b1}} : u1w[DW-1:0];
      p3_cy_in.u2   = '0;
      p3_cy_in.a    = p2_a_ff;
      p3_cy_in.b    = p2_b_ff;
      p3_cy_in.ctr  = p2_ctr_ff;
      p3_cy_in.cb   = AW'(p2_c_ff) + AW'(p2_b_ff);
      p3_cy_in.psum = AW'(p2_c_ff) + AW'(p2_b_ff) + AW'(p2_a_ff);
   end

   // ---------------- stage 4: squared differences ----------------
   logic           p4_v_ff;
   logic [SQW-1:0] p4_sbc_ff, p4_sab_ff, p4_sac_ff;
   logic [F2W-1:0] p4_f2_ff;
   carry_type      p4_cy_ff;
   logic [SQW-1:0] p4_sbc_in, p4_sab_in, p4_sac_in;

   assign p4_sbc_in = p3_dbc_ff * p3_dbc_ff;
   assign p4_sab_in = p3_dab_ff * p3_dab_ff;
   assign p4_sac_in = p3_dac_ff * p3_dac_ff;

   // ---------------- stage 5: 2-D discriminant, 3-D penalty sum ----------------
   logic             p5_v_ff;
   logic [SQW-1:0]   p5_neg3_ff;
   logic [DISCW-1:0] p5_disc2_ff;
   logic [F2W-1:0]   p5_f2_ff;
   carry_type        p5_cy_ff;
   logic [SQW-1:0]   p5_neg3_in;
   logic [DISCW-1:0] p5_disc2_in;

   always_comb begin
      logic [SQW-1:0] two_f2;
      two_f2      = SQW'(p4_f2_ff) << 1;
      p5_disc2_in = (two_f2 > p4_sbc_ff) ? DISCW'(two_f2 - p4_sbc_ff) : '0;
      p5_neg3_in  = p4_sab_ff + p4_sbc_ff + p4_sac_ff;
   end

   // ---------------- stage 6: 3-D discriminant ----------------
   logic             p6_v_ff;
   logic [DISCW-1:0] p6_disc2_ff, p6_disc3_ff;
   carry_type        p6_cy_ff;
   logic [DISCW-1:0] p6_disc3_in;

   always_comb begin
      logic [SQW-1:0] three_f2;
      three_f2    = (SQW'(p5_f2_ff) << 1) + SQW'(p5_f2_ff);
      p6_disc3_in = (three_f2 > p5_neg3_ff) ? DISCW'(three_f2 - p5_neg3_ff) : '0;
   end

   // ---------------- simple stage registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
         p6_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= req_valid;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
         p6_v_ff <= p5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_m0_ff    <= p1_m0_in;
         p1_m1_ff    <= p1_m1_in;
         p1_m2_ff    <= p1_m2_in;
         p1_ctr_ff   <= req_center_distance;
         p1_f_ff     <= sos_ff;
         p2_a_ff     <= p2_a_in;
         p2_b_ff     <= p2_b_in;
         p2_c_ff     <= p2_c_in;
         p2_ctr_ff   <= p1_ctr_ff;
         p2_f_ff     <= p1_f_ff;
         p2_f2_ff    <= p2_f2_in;
         p3_dbc_ff   <= p3_dbc_in;
         p3_dab_ff   <= p3_dab_in;
         p3_dac_ff   <= p3_dac_in;
         p3_f2_ff    <= p2_f2_ff;
         p3_cy_ff    <= p3_cy_in;
         p4_sbc_ff   <= p4_sbc_in;
         p4_sab_ff   <= p4_sab_in;
         p4_sac_ff   <= p4_sac_in;
         p4_f2_ff    <= p3_f2_ff;
         p4_cy_ff    <= p3_cy_ff;
         p5_neg3_ff  <= p5_neg3_in;
         p5_disc2_ff <= p5_disc2_in;
         p5_f2_ff    <= p4_f2_ff;
         p5_cy_ff    <= p4_cy_ff;
         p6_disc2_ff <= p5_disc2_ff;
         p6_disc3_ff <= p6_disc3_in;
         p6_cy_ff    <= p5_cy_ff;
      end
   end

   // ---------------- square root pipelines, one root bit per stage ----------------
   logic             sq_v_ff  [NSQ];
   logic [DISCW-1:0] sq_x2_ff [NSQ];
   logic [DISCW-1:0] sq_r2_ff [NSQ];
   logic [DISCW-1:0] sq_x3_ff [NSQ];
   logic [DISCW-1:0] sq_r3_ff [NSQ];
   carry_type        sq_cy_ff [NSQ];

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      localparam logic [DISCW-1:0] BIT = DISCW'(1) << (2 * (NSQ - 1 - k));
      logic             v_src;
      logic [DISCW-1:0] x2_src, r2_src, x3_src, r3_src;
      carry_type        cy_src;
      logic [DISCW-1:0] x2_in, r2_in, x3_in, r3_in;

      if (k == 0) begin : g_head
         assign v_src  = p6_v_ff;
         assign x2_src = p6_disc2_ff;
         assign r2_src = '0;
         assign x3_src = p6_disc3_ff;
         assign r3_src = '0;
         assign cy_src = p6_cy_ff;
      end else begin : g_body
         assign v_src  = sq_v_ff[k-1];
         assign x2_src = sq_x2_ff[k-1];
         assign r2_src = sq_r2_ff[k-1];
         assign x3_src = sq_x3_ff[k-1];
         assign r3_src = sq_r3_ff[k-1];
         assign cy_src = sq_cy_ff[k-1];
      end

      always_comb begin
         logic [DISCW-1:0] t2, t3;
         t2 = r2_src + BIT;
         t3 = r3_src + BIT;
         if (x2_src >= t2) begin
            x2_in = x2_src - t2;
            r2_in = (r2_src >> 1) + BIT;
         end else begin
            x2_in = x2_src;
            r2_in = r2_src >> 1;
         end
         if (x3_src >= t3) begin
            x3_in = x3_src - t3;
            r3_in = (r3_src >> 1) + BIT;
         end else begin
            x3_in = x3_src;
            r3_in = r3_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_x2_ff[k] <= x2_in;
            sq_r2_ff[k] <= r2_in;
            sq_x3_ff[k] <= x3_in;
            sq_r3_ff[k] <= r3_in;
            sq_cy_ff[k] <= cy_src;
         end
      end
   end

   // ---------------- stage 7: 2-D candidate, 3-D numerator ----------------
   logic          p7_v_ff;
   logic [AW-1:0] p7_t3_ff;
   carry_type     p7_cy_ff;
   logic [AW-1:0] p7_t3_in;
   carry_type     p7_cy_in;

   always_comb begin
      logic [AW-1:0] u2w;
      p7_cy_in    = sq_cy_ff[NSQ-1];
      u2w         = (sq_cy_ff[NSQ-1].cb + AW'(sq_r2_ff[NSQ-1][NSQ-1:0])) >> 1;
      p7_cy_in.u2 = (u2w > DMAX_A) ? {DW{1'b1}} : u2w[DW-1:0];
      p7_t3_in    = sq_cy_ff[NSQ-1].psum + AW'(sq_r3_ff[NSQ-1][NSQ-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_v_ff <= 1'b0;
      end else if (en) begin
         p7_v_ff <= sq_v_ff[NSQ-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p7_t3_ff <= p7_t3_in;
         p7_cy_ff <= p7_cy_in;
      end
   end

   // ---------------- divide by three, DB dividend bits per stage ----------------
   logic            dv_v_ff   [NDIV];
   logic [DIVW-1:0] dv_n_ff   [NDIV];
   logic [DIVW-1:0] dv_q_ff   [NDIV];
   logic [1:0]      dv_rem_ff [NDIV];
   carry_type       dv_cy_ff  [NDIV];

   for (genvar j = 0; j < NDIV; j++) begin : g_div
      logic            v_src;
      logic [DIVW-1:0] n_src, q_src;
      logic [1:0]      rem_src;
      carry_type       cy_src;
      logic [DIVW-1:0] n_in, q_in;
      logic [1:0]      rem_in;

      if (j == 0) begin : g_head
         assign v_src   = p7_v_ff;
         assign n_src   = DIVW'(p7_t3_ff);
         assign q_src   = '0;
         assign rem_src = '0;
         assign cy_src  = p7_cy_ff;
      end else begin : g_body
         assign v_src   = dv_v_ff[j-1];
         assign n_src   = dv_n_ff[j-1];
         assign q_src   = dv_q_ff[j-1];
         assign rem_src = dv_rem_ff[j-1];
         assign cy_src  = dv_cy_ff[j-1];
      end

      always_comb begin
         logic [2:0]      rr;
         logic [1:0]      rem;
         logic [DIVW-1:0] q;
         rem = rem_src;
         q   = q_src;
         for (int i = 0; i < DB; i++) begin
            rr = {rem, n_src[DIVW-1-i]};
            if (rr >= 3'd3) begin
               rem = 2'(rr - 3'd3);
               q   = {q[DIVW-2:0], 1'b1};
            end else begin
               rem = rr[1:0];
               q   = {q[DIVW-2:0], 1'b0};
            end
         end
         rem_in = rem;
         q_in   = q;
         n_in   = n_src << DB;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (en) begin
            dv_v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_n_ff[j]   <= n_in;
            dv_q_ff[j]   <= q_in;
            dv_rem_ff[j] <= rem_in;
            dv_cy_ff[j]  <= cy_src;
         end
      end
   end

   // ---------------- output register: candidate selection ----------------
   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_dist_ff;
   logic          rsp_imp_ff;
   logic [DW-1:0] rsp_dist_in;
   logic          rsp_imp_in;

   always_comb begin
      carry_type     cy;
      logic [DW-1:0] u3;
      cy = dv_cy_ff[NDIV-1];
      u3 = (dv_q_ff[NDIV-1] > DIVW'(DMAX_A)) ? {DW{1'b1}} : dv_q_ff[NDIV-1][DW-1:0];
      if (cy.u1 <= cy.b) begin
         rsp_dist_in = cy.u1;
      end else if (cy.u2 <= cy.a) begin
         rsp_dist_in = cy.u2;
      end else begin
         rsp_dist_in = u3;
      end
      rsp_imp_in = (rsp_dist_in < cy.ctr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_v_ff[NDIV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_dist_ff <= rsp_dist_in;
         rsp_imp_ff  <= rsp_imp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_distance = rsp_dist_ff;
   assign rsp_improved     = rsp_imp_ff;

endmodule

FILE: hw/rtl/eik_checker.sv
// ----------------------------------------------------------------------------
// eik_checker
// Port-level assertions for the eikonal node update unit, bound to the top.
// ----------------------------------------------------------------------------
module eik_checker #(
   parameter int DIST_WIDTH = eik_pkg::DIST_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DIST_WIDTH-1:0] rsp_new_distance,
   input logic                  rsp_improved
);

   // no results straight out of reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // input is taken whenever the output register can move
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output backpressure");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_distance)
                                  && $stable(rsp_improved))
      else $error("stalled result changed");

   // an improved distance is below some value, so never the unreached code
   a_improved_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_improved |-> rsp_new_distance != {DIST_WIDTH{1'b1}})
      else $error("improved flag on an unreached distance");

endmodule

bind eikonal_node_update_3d_unit eik_checker #(
   .DIST_WIDTH (DIST_WIDTH)
) u_eik_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_new_distance (rsp_new_distance),
   .rsp_improved     (rsp_improved)
);
